[rtl/core/mt_pkg.sv]
// ----------------------------------------------------------------------------
// mt_pkg
// Shared types, constants and word functions of the MT19937 generator.
// ----------------------------------------------------------------------------
package mt_pkg;

    localparam int MT_N     = 624;                 // state words
    localparam int MT_M     = 397;                 // middle tap offset
    localparam int MT_IDX_W = $clog2(MT_N + 1);    // holds 0..MT_N

    localparam logic [31:0] MT_INIT_MULT = 32'h6c078965;
    localparam logic [31:0] MT_TEMPER_B  = 32'h9d2c5680;
    localparam logic [31:0] MT_TEMPER_C  = 32'hefc60000;
    localparam logic [31:0] MT_MATRIX    = 32'h9908b0df;
    localparam logic [31:0] MT_UPPER     = 32'h80000000;
    localparam logic [31:0] MT_LOWER     = 32'h7fffffff;
    localparam logic [31:0] MT_SEED_RST  = 32'd5489;

    typedef logic [31:0]         t_word;
    typedef logic [MT_IDX_W-1:0] t_idx;

    // Control of the shift ring: advance every cell one place toward the head.
    typedef struct packed {
        logic  shift;
        t_word shift_in;
        t_word load_val;
    } t_ring_ctl;

    function automatic t_word mt_init_next(t_word prev, t_idx i);
        t_word mix;
        t_word prod;
        mix  = prev ^ (prev >> 30);
        prod = t_word'(MT_INIT_MULT * mix);
        return prod + t_word'(i);
    endfunction

    function automatic t_word mt_twist(t_word cur, t_word nxt, t_word mid);
        t_word x;
        t_word y;
        x = (cur & MT_UPPER) | (nxt & MT_LOWER);
        y = mid ^ (x >> 1);
        if (x[0]) begin
            y = y ^ MT_MATRIX;
        end
        return y;
    endfunction

    function automatic t_word mt_temper(t_word w);
        t_word y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

[rtl/core/mt_cell.sv]
// ----------------------------------------------------------------------------
// mt_cell
// One state word of the ring: takes its neighbor's word on a shift, or a
// direct load.
// ----------------------------------------------------------------------------
module mt_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  mt_pkg::t_word i_shift_in,
    input  logic          i_load,
    input  mt_pkg::t_word i_load_val,
    output mt_pkg::t_word o_word
);

    mt_pkg::t_word r_word;
    mt_pkg::t_word n_word;

    always_comb begin
        n_word = r_word;
        if (i_load) begin
            n_word = i_load_val;
        end else if (i_shift) begin
            n_word = i_shift_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

[rtl/core/mt_ring.sv]
// ----------------------------------------------------------------------------
// mt_ring
// Chain of state cells. Cell 0 is the head; new words enter at the tail.
// Fixed taps feed the twist, the initializer and the tempering output.
// ----------------------------------------------------------------------------
module mt_ring (
    input  logic                  i_clk,
    input  mt_pkg::t_ring_ctl     i_ctl,
    input  logic [mt_pkg::MT_N-1:0] i_wen,
    output mt_pkg::t_word         o_head,
    output mt_pkg::t_word         o_next,
    output mt_pkg::t_word         o_mid,
    output mt_pkg::t_word         o_tail
);

    mt_pkg::t_word words [mt_pkg::MT_N];
    mt_pkg::t_word feed  [mt_pkg::MT_N];

    genvar k;
    generate
        for (k = 0; k < mt_pkg::MT_N; k++) begin : g_cell
            if (k == mt_pkg::MT_N - 1) begin : g_tail
                assign feed[k] = i_ctl.shift_in;
            end else begin : g_body
                assign feed[k] = words[k+1];
            end

            mt_cell u_cell (
                .i_clk      (i_clk),
                .i_shift    (i_ctl.shift),
                .i_shift_in (feed[k]),
                .i_load     (i_wen[k]),
                .i_load_val (i_ctl.load_val),
                .o_word     (words[k])
            );
        end
    endgenerate

    assign o_head = words[0];
    assign o_next = words[1];
    assign o_mid  = words[mt_pkg::MT_M];
    assign o_tail = words[mt_pkg::MT_N-1];

endmodule

[rtl/core/mt19937_generator.sv]
// ----------------------------------------------------------------------------
// mt19937_generator
// MT19937 32-bit pseudo-random source built on a ring of 624 word cells.
//
//  channel  dir  handshake                   payload
//  s        in   i_s_tvalid / o_s_tready     tdata: word_index, word_value
//                                            tuser: action
//  m        out  o_m_tvalid / i_m_tready     tdata: random_value
//  cfg      in   i_cfg_valid / o_cfg_ready   data: seed
//
// A draw is answered from the head of the ring while the read position is
// inside the bank; every 624th draw first runs a twist pass through the
// ring and then reads the new head.
// After reset and after each seed write a fill pass shifts the
// initializer output into the ring; no request is taken meanwhile.
// o_s_tready drops while a result waits in the output register and is not
// taken in that cycle.
// ----------------------------------------------------------------------------
module mt19937_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [9:0] word_index, [41:10] word_value, [47:42] zero
    input  logic [0:0]  i_s_tuser,   // [0] action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] random_value
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data   // [31:0] seed
);

    localparam int N = mt_pkg::MT_N;
    localparam int W = mt_pkg::MT_IDX_W;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_IDLE,
        ST_TWIST,
        ST_DRAW
    } t_state;

    t_state            r_state;
    mt_pkg::t_idx      r_cnt;
    mt_pkg::t_idx      r_pos;
    mt_pkg::t_word     r_seed;
    logic              r_m_valid;
    mt_pkg::t_word     r_m_data;

    mt_pkg::t_ring_ctl ring_ctl;
    logic [N-1:0]      wen;
    mt_pkg::t_word     head;
    mt_pkg::t_word     next_w;
    mt_pkg::t_word     mid;
    mt_pkg::t_word     tail;

    logic              s_ready;
    logic              accept;
    logic              is_load;
    logic              draw;
    logic              cfg_wr;
    logic              pos_end;
    mt_pkg::t_idx      ld_idx;
    logic              ld_en;
    mt_pkg::t_idx      ofs;
    logic [W:0]        wrap_sum;
    mt_pkg::t_idx      target;

    assign s_ready = (r_state == ST_IDLE) && (!r_m_valid || i_m_tready);
    assign accept  = i_s_tvalid && s_ready;
    assign is_load = i_s_tuser[0];
    assign draw    = accept && !is_load;
    assign cfg_wr  = i_cfg_valid;
    assign pos_end = (r_pos == W'(N));

    // Head of the ring holds the word at the read position; map a load index
    // onto the cell that currently holds it.
    assign ld_idx   = i_s_tdata[9:0];
    assign ld_en    = accept && is_load && (ld_idx < W'(N));
    assign ofs      = pos_end ? '0 : r_pos;
    assign wrap_sum = {1'b0, ld_idx} + (W+1)'(N) - {1'b0, ofs};
    assign target   = (ld_idx >= ofs) ? (ld_idx - ofs) : wrap_sum[W-1:0];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_wen
            assign wen[k] = ld_en && (target == W'(k));
        end
    endgenerate

    always_comb begin
        ring_ctl.shift    = 1'b0;
        ring_ctl.shift_in = head;
        ring_ctl.load_val = i_s_tdata[41:10];
        case (r_state)
            ST_FILL: begin
                ring_ctl.shift    = 1'b1;
                ring_ctl.shift_in = (r_cnt == '0) ? r_seed : mt_pkg::mt_init_next(tail, r_cnt);
            end
            ST_TWIST: begin
                ring_ctl.shift    = 1'b1;
                ring_ctl.shift_in = mt_pkg::mt_twist(head, next_w, mid);
            end
            ST_IDLE: begin
                // rotate: the drawn word goes back in at the tail
                ring_ctl.shift = draw && !pos_end;
            end
            ST_DRAW: begin
                ring_ctl.shift = 1'b1;
            end
            default: begin
                ring_ctl.shift = 1'b0;
            end
        endcase
    end

    mt_ring u_ring (
        .i_clk  (i_clk),
        .i_ctl  (ring_ctl),
        .i_wen  (wen),
        .o_head (head),
        .o_next (next_w),
        .o_mid  (mid),
        .o_tail (tail)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_cnt     <= '0;
            r_pos     <= W'(N);
            r_seed    <= mt_pkg::MT_SEED_RST;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_FILL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == W'(N - 1)) begin
                        r_cnt   <= '0;
                        r_pos   <= W'(N);
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (draw) begin
                        if (pos_end) begin
                            r_cnt   <= '0;
                            r_state <= ST_TWIST;
                        end else begin
                            r_m_valid <= 1'b1;
                            r_m_data  <= mt_pkg::mt_temper(head);
                            r_pos     <= r_pos + 1'b1;
                        end
                    end
                end
                ST_TWIST: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == W'(N - 1)) begin
                        r_cnt   <= '0;
                        r_state <= ST_DRAW;
                    end
                end
                ST_DRAW: begin
                    r_m_valid <= 1'b1;
                    r_m_data  <= mt_pkg::mt_temper(head);
                    r_pos     <= W'(1);
                    r_state   <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            // a seed write restarts the fill pass
            if (cfg_wr) begin
                r_seed  <= i_cfg_data;
                r_cnt   <= '0;
                r_pos   <= W'(N);
                r_state <= ST_FILL;
            end
        end
    end

    assign o_s_tready  = s_ready;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;
    assign o_cfg_ready = 1'b1;

endmodule
